// ----- rtl/voxel_grid_lowest_point_filter_macros.svh -----
// Assertion macros for the lowest-point voxel filter.
`ifndef VOXEL_GRID_LOWEST_POINT_FILTER_MACROS_SVH
`define VOXEL_GRID_LOWEST_POINT_FILTER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define VGLPF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vglpf assertion failed");

// next-cycle implication
`define VGLPF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vglpf assertion failed");

`else

`define VGLPF_ASSERT_IMP(label, clk, rst, ante, cons)
`define VGLPF_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/vglpf_pkg.sv -----
package vglpf_pkg;

   localparam int GridCellsDefault = 4096;

   localparam int CoordW   = 32;
   localparam int InvW     = 24;
   localparam int OriginW  = 24;
   localparam int SpanW    = 13;
   localparam int CellIdxW = 12;
   localparam int PointW   = 3 * CoordW;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;

   // datapath widths
   localparam int FracW   = 32;                 // fraction bits of coord * inverse
   localparam int MulAW   = 32;
   localparam int MulBW   = 27;
   localparam int ProdW   = MulAW + MulBW;
   localparam int AxisW   = 28;
   localparam int LinW    = 60;

   localparam logic [CsrIdxW-1:0] CSR_INV_X  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_INV_Y  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_INV_Z  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_ORG_X  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_ORG_Y  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_ORG_Z  = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_SPAN_X = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_SPAN_Y = 3'd7;

   localparam logic [InvW-1:0]    InvXReset  = 24'd6553600;
   localparam logic [InvW-1:0]    InvYReset  = 24'd6553600;
   localparam logic [InvW-1:0]    InvZReset  = 24'd32768;
   localparam logic [SpanW-1:0]   SpanReset  = 13'd64;

   // one memory operation handed to the cell store
   typedef struct packed {
      logic                drain;
      logic                hit;          // address lies inside the grid
      logic [CellIdxW-1:0] cell_index;
      logic [CoordW-1:0]   px;
      logic [CoordW-1:0]   py;
      logic [CoordW-1:0]   pz;
   } cell_op_type;

   typedef struct packed {
      logic [CellIdxW-1:0] cell_index;
      logic                dropped;
      logic                occupied;
      logic [CoordW-1:0]   kept_x;
      logic [CoordW-1:0]   kept_y;
      logic [CoordW-1:0]   kept_z;
   } rsp_type;

endpackage

// ----- rtl/vglpf_index.sv -----
module vglpf_index #(
   parameter int GRID_CELLS = vglpf_pkg::GridCellsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  go,
   input  logic signed [vglpf_pkg::CoordW-1:0]   px,
   input  logic signed [vglpf_pkg::CoordW-1:0]   py,
   input  logic signed [vglpf_pkg::CoordW-1:0]   pz,
   input  logic [vglpf_pkg::InvW-1:0]            inv_x,
   input  logic [vglpf_pkg::InvW-1:0]            inv_y,
   input  logic [vglpf_pkg::InvW-1:0]            inv_z,
   input  logic signed [vglpf_pkg::OriginW-1:0]  org_x,
   input  logic signed [vglpf_pkg::OriginW-1:0]  org_y,
   input  logic signed [vglpf_pkg::OriginW-1:0]  org_z,
   input  logic [vglpf_pkg::SpanW-1:0]           span_x,
   input  logic [vglpf_pkg::SpanW-1:0]           span_y,
   output logic                                  done,
   output vglpf_pkg::cell_op_type                op,
   output logic [$clog2(GRID_CELLS)-1:0]         addr
);
   import vglpf_pkg::*;

   localparam int IdxW = $clog2(GRID_CELLS);

   localparam logic [2:0] ST_MUL_X = 3'd0;
   localparam logic [2:0] ST_MUL_Y = 3'd1;
   localparam logic [2:0] ST_MUL_Z = 3'd2;
   localparam logic [2:0] ST_AREA  = 3'd3;
   localparam logic [2:0] ST_ROW   = 3'd4;
   localparam logic [2:0] ST_ZOFF  = 3'd5;
   localparam logic [2:0] ST_LIN   = 3'd6;

   logic                      run_ff, run_in;
   logic [2:0]                step_ff, step_in;
   logic signed [CoordW-1:0]  px_ff, py_ff, pz_ff;
   logic signed [ProdW-1:0]   prod_ff;
   logic signed [AxisW-1:0]   ix_ff, iy_ff, iz_ff;
   logic signed [MulBW-1:0]   area_ff;
   logic signed [LinW-1:0]    base_ff;
   logic                      oor_ff;
   logic                      done_ff, done_in;
   cell_op_type               op_ff, op_in;
   logic [IdxW-1:0]           addr_ff;

   logic signed [MulAW-1:0]   mul_a;
   logic signed [MulBW-1:0]   mul_b;
   logic signed [ProdW-1:0]   mul_p;
   logic signed [ProdW-FracW-1:0] floor_cell;
   logic signed [AxisW-1:0]   axis_val;
   logic signed [AxisW-1:0]   spx_s, spy_s;
   logic signed [LinW-1:0]    lin;
   logic                      oor;
   logic                      hit;

   // one shared multiplier, operands chosen by step
   always_comb begin
      case (step_ff)
         ST_MUL_X: begin
            mul_a = px_ff;
            mul_b = MulBW'(inv_x);
         end
         ST_MUL_Y: begin
            mul_a = py_ff;
            mul_b = MulBW'(inv_y);
         end
         ST_MUL_Z: begin
            mul_a = pz_ff;
            mul_b = MulBW'(inv_z);
         end
         ST_AREA: begin
            mul_a = MulAW'(span_x);
            mul_b = MulBW'(span_y);
         end
         ST_ROW: begin
            mul_a = MulAW'(iy_ff);
            mul_b = MulBW'(span_x);
         end
         ST_ZOFF: begin
            mul_a = MulAW'(iz_ff);
            mul_b = area_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // arithmetic shift floors toward minus infinity
   assign floor_cell = $signed(prod_ff[ProdW-1:FracW]);

   always_comb begin
      case (step_ff)
         ST_MUL_Y: axis_val = AxisW'(floor_cell) - AxisW'(org_x);
         ST_MUL_Z: axis_val = AxisW'(floor_cell) - AxisW'(org_y);
         default:  axis_val = AxisW'(floor_cell) - AxisW'(org_z);
      endcase
   end

   assign spx_s = AxisW'(span_x);
   assign spy_s = AxisW'(span_y);
   assign oor   = (ix_ff < 0) || (ix_ff >= spx_s) || (iy_ff < 0) || (iy_ff >= spy_s)
                  || (iz_ff < 0);

   assign lin = base_ff + LinW'(prod_ff);
   assign hit = !oor_ff && (lin < LinW'(GRID_CELLS));

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (go) begin
         run_in  = 1'b1;
         step_in = ST_MUL_X;
      end else if (run_ff) begin
         if (step_ff == ST_LIN) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_comb begin
      op_in            = op_ff;
      op_in.drain      = 1'b0;
      op_in.hit        = hit;
      op_in.cell_index = hit ? lin[CellIdxW-1:0] : '0;
      op_in.px         = px_ff;
      op_in.py         = py_ff;
      op_in.pz         = pz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= ST_MUL_X;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         px_ff <= px;
         py_ff <= py;
         pz_ff <= pz;
      end
      prod_ff <= mul_p;
      case (step_ff)
         ST_MUL_Y: ix_ff <= axis_val;
         ST_MUL_Z: iy_ff <= axis_val;
         ST_AREA:  iz_ff <= axis_val;
         ST_ROW: begin
            area_ff <= prod_ff[MulBW-1:0];
            oor_ff  <= oor;
         end
         ST_ZOFF: base_ff <= LinW'(ix_ff) + LinW'(prod_ff);
         default: ;
      endcase
      if (done_in) begin
         op_ff   <= op_in;
         addr_ff <= lin[IdxW-1:0];
      end
   end

   assign done = done_ff;
   assign op   = op_ff;
   assign addr = addr_ff;

endmodule

// ----- rtl/vglpf_cell_store.sv -----
module vglpf_cell_store #(
   parameter int GRID_CELLS = vglpf_pkg::GridCellsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           op_valid,
   input  vglpf_pkg::cell_op_type         op,
   input  logic [$clog2(GRID_CELLS)-1:0]  op_addr,
   output logic                           clearing,
   output logic                           rsp_valid,
   output vglpf_pkg::rsp_type             rsp
);
   import vglpf_pkg::*;

   localparam int IdxW = $clog2(GRID_CELLS);

   logic                 vld_mem [GRID_CELLS];
   logic [PointW-1:0]    pt_mem  [GRID_CELLS];

   logic                 clr_ff;
   logic [IdxW-1:0]      clr_cnt_ff;
   logic                 pend_ff;
   cell_op_type          op_ff;
   logic [IdxW-1:0]      addr_ff;
   logic                 vld_rd_ff;
   logic [PointW-1:0]    pt_rd_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [PointW-1:0]    new_pt;
   logic [CoordW-1:0]    rd_y;
   logic                 take;
   logic                 occ;

   // valid store is swept to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         if (clr_cnt_ff == IdxW'(GRID_CELLS - 1)) begin
            clr_ff <= 1'b0;
         end else begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      vld_rd_ff <= vld_mem[op_addr];
      pt_rd_ff  <= pt_mem[op_addr];
      op_ff     <= op;
      addr_ff   <= op_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= op_valid;
         rsp_valid_ff <= pend_ff;
      end
   end

   // modify stage
   assign new_pt = {op_ff.px, op_ff.py, op_ff.pz};
   assign rd_y   = pt_rd_ff[2*CoordW-1:CoordW];
   assign take   = pend_ff && op_ff.hit && !op_ff.drain
                   && (!vld_rd_ff || ($signed(op_ff.py) < $signed(rd_y)));
   assign occ    = op_ff.hit && (op_ff.drain ? vld_rd_ff : 1'b1);

   always_comb begin
      rsp_in.cell_index = op_ff.cell_index;
      rsp_in.dropped    = !op_ff.drain && !op_ff.hit;
      rsp_in.occupied   = occ;
      if (!occ) begin
         {rsp_in.kept_x, rsp_in.kept_y, rsp_in.kept_z} = '0;
      end else if (take) begin
         {rsp_in.kept_x, rsp_in.kept_y, rsp_in.kept_z} = new_pt;
      end else begin
         {rsp_in.kept_x, rsp_in.kept_y, rsp_in.kept_z} = pt_rd_ff;
      end
   end

   // write back: drain clears, insert sets (already set when not taken)
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         vld_mem[clr_cnt_ff] <= 1'b0;
      end else if (pend_ff && op_ff.hit) begin
         vld_mem[addr_ff] <= !op_ff.drain;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pt_mem[addr_ff] <= new_pt;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign clearing  = clr_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/voxel_grid_lowest_point_filter.sv -----
// Lowest-point voxel filter: keeps, per grid cell, the point with the smallest y.
// Command channel: an item is taken at a clock edge with start high and busy low.
// req_mode 0 inserts point (req_px, req_py, req_pz); req_mode 1 reads and clears
// cell req_drain_cell.
// Result channel: one word per item, held for one cycle with rsp_valid high; the
// receiver must take it in that cycle.
// busy stays high through the result cycle, so the block takes a new item only
// after the result word of the item before it. Inserts are paced by the single
// shared multiplier doing six products in turn (three axis scalings, the plane
// area, row and plane offsets); both kinds then go through the read stage and
// the write-back stage of the cell memories.
// csr_* writes the eight setup registers; csr_ready is always high. Write only
// while busy is low and no result is pending.
// Reset: the setup registers take their defaults, and the occupancy memory is
// swept to empty while busy is held high.
`include "voxel_grid_lowest_point_filter_macros.svh"

module voxel_grid_lowest_point_filter #(
   parameter int GRID_CELLS = vglpf_pkg::GridCellsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_mode,
   input  logic signed [vglpf_pkg::CoordW-1:0]   req_px,
   input  logic signed [vglpf_pkg::CoordW-1:0]   req_py,
   input  logic signed [vglpf_pkg::CoordW-1:0]   req_pz,
   input  logic [vglpf_pkg::CellIdxW-1:0]        req_drain_cell,
   output logic                                  rsp_valid,
   output logic [vglpf_pkg::CellIdxW-1:0]        rsp_cell_index,
   output logic                                  rsp_dropped,
   output logic                                  rsp_occupied,
   output logic signed [vglpf_pkg::CoordW-1:0]   rsp_kept_x,
   output logic signed [vglpf_pkg::CoordW-1:0]   rsp_kept_y,
   output logic signed [vglpf_pkg::CoordW-1:0]   rsp_kept_z,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vglpf_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [vglpf_pkg::CsrDataW-1:0]        csr_data
);
   import vglpf_pkg::*;

   localparam int IdxW = $clog2(GRID_CELLS);

   logic [InvW-1:0]           inv_x_ff, inv_y_ff, inv_z_ff;
   logic signed [OriginW-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic [SpanW-1:0]          span_x_ff, span_y_ff;

   logic                      busy_ff;
   logic                      accept;
   logic                      clearing;

   logic                      drn_valid_ff;
   cell_op_type               drn_op_ff, drn_op_in;
   logic [IdxW-1:0]           drn_addr_ff;
   logic [IdxW+CellIdxW-1:0]  drn_ext;

   logic                      idx_done;
   cell_op_type               idx_op;
   logic [IdxW-1:0]           idx_addr;

   logic                      st_valid;
   cell_op_type               st_op;
   logic [IdxW-1:0]           st_addr;
   logic                      st_rsp_valid;
   rsp_type                   st_rsp;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = busy_ff || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff  <= InvXReset;
         inv_y_ff  <= InvYReset;
         inv_z_ff  <= InvZReset;
         org_x_ff  <= '0;
         org_y_ff  <= '0;
         org_z_ff  <= '0;
         span_x_ff <= SpanReset;
         span_y_ff <= SpanReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INV_X:  inv_x_ff  <= csr_data;
            CSR_INV_Y:  inv_y_ff  <= csr_data;
            CSR_INV_Z:  inv_z_ff  <= csr_data;
            CSR_ORG_X:  org_x_ff  <= csr_data;
            CSR_ORG_Y:  org_y_ff  <= csr_data;
            CSR_ORG_Z:  org_z_ff  <= csr_data;
            CSR_SPAN_X: span_x_ff <= csr_data[SpanW-1:0];
            CSR_SPAN_Y: span_y_ff <= csr_data[SpanW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         drn_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (st_rsp_valid) begin
            busy_ff <= 1'b0;
         end
         drn_valid_ff <= accept && req_mode;
      end
   end

   // drain goes straight to the store
   assign drn_ext = {{IdxW{1'b0}}, req_drain_cell};

   always_comb begin
      drn_op_in            = drn_op_ff;
      drn_op_in.drain      = 1'b1;
      drn_op_in.hit        = 32'(req_drain_cell) < 32'(GRID_CELLS);
      drn_op_in.cell_index = req_drain_cell;
      drn_op_in.px         = '0;
      drn_op_in.py         = '0;
      drn_op_in.pz         = '0;
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode) begin
         drn_op_ff   <= drn_op_in;
         drn_addr_ff <= drn_ext[IdxW-1:0];
      end
   end

   vglpf_index #(
      .GRID_CELLS(GRID_CELLS)
   ) u_index (
      .clock  (clock),
      .reset  (reset),
      .go     (accept && !req_mode),
      .px     (req_px),
      .py     (req_py),
      .pz     (req_pz),
      .inv_x  (inv_x_ff),
      .inv_y  (inv_y_ff),
      .inv_z  (inv_z_ff),
      .org_x  (org_x_ff),
      .org_y  (org_y_ff),
      .org_z  (org_z_ff),
      .span_x (span_x_ff),
      .span_y (span_y_ff),
      .done   (idx_done),
      .op     (idx_op),
      .addr   (idx_addr)
   );

   assign st_valid = drn_valid_ff || idx_done;
   assign st_op    = drn_valid_ff ? drn_op_ff : idx_op;
   assign st_addr  = drn_valid_ff ? drn_addr_ff : idx_addr;

   vglpf_cell_store #(
      .GRID_CELLS(GRID_CELLS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (st_valid),
      .op        (st_op),
      .op_addr   (st_addr),
      .clearing  (clearing),
      .rsp_valid (st_rsp_valid),
      .rsp       (st_rsp)
   );

   assign rsp_valid      = st_rsp_valid;
   assign rsp_cell_index = st_rsp.cell_index;
   assign rsp_dropped    = st_rsp.dropped;
   assign rsp_occupied   = st_rsp.occupied;
   assign rsp_kept_x     = st_rsp.kept_x;
   assign rsp_kept_y     = st_rsp.kept_y;
   assign rsp_kept_z     = st_rsp.kept_z;

   `VGLPF_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `VGLPF_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `VGLPF_ASSERT_IMP(a_rsp_in_flight, clock, reset, rsp_valid, busy_ff && !clearing)
   `VGLPF_ASSERT_IMP(a_dropped_empty, clock, reset, rsp_valid && rsp_dropped, !rsp_occupied)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

typedef enum logic {OP_INSERT = 1'b0, OP_DRAIN = 1'b1} op_kind_type;

// Tracks the cell store and setup registers; predicts one result word per item.
class voxel_cell_tracker;
   longint inv_x, inv_y, inv_z;
   longint org_x, org_y, org_z;
   longint span_x, span_y;
   bit occupied [vglpf_pkg::GridCellsDefault];
   bit ever_kept [vglpf_pkg::GridCellsDefault];
   logic [31:0] held_x [vglpf_pkg::GridCellsDefault];
   logic [31:0] held_y [vglpf_pkg::GridCellsDefault];
   logic [31:0] held_z [vglpf_pkg::GridCellsDefault];
   int kept_slots[$];
   int recent_slots[$];
   vglpf_pkg::rsp_type owed_words[$];
   int bad_words;

   function new();
      inv_x = longint'(vglpf_pkg::InvXReset);
      inv_y = longint'(vglpf_pkg::InvYReset);
      inv_z = longint'(vglpf_pkg::InvZReset);
      org_x = 0;
      org_y = 0;
      org_z = 0;
      span_x = longint'(vglpf_pkg::SpanReset);
      span_y = longint'(vglpf_pkg::SpanReset);
      bad_words = 0;
   endfunction

   function void set_reg(logic [vglpf_pkg::CsrIdxW-1:0] idx,
                         logic [vglpf_pkg::CsrDataW-1:0] value);
      case (idx)
         vglpf_pkg::CSR_INV_X:  inv_x = longint'(value);
         vglpf_pkg::CSR_INV_Y:  inv_y = longint'(value);
         vglpf_pkg::CSR_INV_Z:  inv_z = longint'(value);
         vglpf_pkg::CSR_ORG_X:  org_x = longint'($signed(value));
         vglpf_pkg::CSR_ORG_Y:  org_y = longint'($signed(value));
         vglpf_pkg::CSR_ORG_Z:  org_z = longint'($signed(value));
         vglpf_pkg::CSR_SPAN_X: span_x = longint'(value[12:0]);
         vglpf_pkg::CSR_SPAN_Y: span_y = longint'(value[12:0]);
         default: ;
      endcase
   endfunction

   // exact Q16.16 * Q8.16 product, floored toward minus infinity
   function longint cells_of(logic [31:0] coord, longint inv);
      longint prod;
      prod = longint'($signed(coord)) * inv;
      return prod >>> 32;
   endfunction

   function void accept_item(logic mode, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [11:0] drain_slot);
      vglpf_pkg::rsp_type w;
      longint ix, iy, iz, lin;
      int s;
      w = '0;
      if (mode == OP_DRAIN) begin
         s = int'(drain_slot);
         w.cell_index = drain_slot;
         if (occupied[s]) begin
            w.occupied = 1'b1;
            w.kept_x = held_x[s];
            w.kept_y = held_y[s];
            w.kept_z = held_z[s];
            occupied[s] = 1'b0;
         end
      end else begin
         ix = cells_of(px, inv_x) - org_x;
         iy = cells_of(py, inv_y) - org_y;
         iz = cells_of(pz, inv_z) - org_z;
         lin = ix + iy * span_x + iz * span_x * span_y;
         if (ix < 0 || ix >= span_x || iy < 0 || iy >= span_y || iz < 0 ||
             lin >= vglpf_pkg::GridCellsDefault) begin
            w.dropped = 1'b1;
         end else begin
            s = int'(lin);
            // strict compare: on equal y the earlier point stays
            if (!occupied[s] || $signed(py) < $signed(held_y[s])) begin
               occupied[s] = 1'b1;
               held_x[s] = px;
               held_y[s] = py;
               held_z[s] = pz;
               if (!ever_kept[s]) begin
                  ever_kept[s] = 1'b1;
                  kept_slots.push_back(s);
               end
            end
            recent_slots.push_back(s);
            if (recent_slots.size() > 16)
               void'(recent_slots.pop_front());
            w.cell_index = s[11:0];
            w.occupied = 1'b1;
            w.kept_x = held_x[s];
            w.kept_y = held_y[s];
            w.kept_z = held_z[s];
         end
      end
      owed_words.push_back(w);
   endfunction

   function void check_word(vglpf_pkg::rsp_type got);
      vglpf_pkg::rsp_type w;
      string bad;
      if (owed_words.size() == 0) begin
         bad_words++;
         if (bad_words <= 10)
            $display("unexpected result word: cell %0d dropped %0b occupied %0b",
                     got.cell_index, got.dropped, got.occupied);
         return;
      end
      w = owed_words.pop_front();
      bad = "";
      if (got.cell_index !== w.cell_index) bad = {bad, " cell_index"};
      if (got.dropped !== w.dropped) bad = {bad, " dropped"};
      if (got.occupied !== w.occupied) bad = {bad, " occupied"};
      if (got.kept_x !== w.kept_x) bad = {bad, " kept_x"};
      if (got.kept_y !== w.kept_y) bad = {bad, " kept_y"};
      if (got.kept_z !== w.kept_z) bad = {bad, " kept_z"};
      if (bad != "") begin
         bad_words++;
         if (bad_words <= 10) begin
            $display("mismatch in%s", bad);
            $display("  expected cell %0d drop %0b occ %0b x %h y %h z %h",
                     w.cell_index, w.dropped, w.occupied, w.kept_x, w.kept_y, w.kept_z);
            $display("  actual   cell %0d drop %0b occ %0b x %h y %h z %h",
                     got.cell_index, got.dropped, got.occupied,
                     got.kept_x, got.kept_y, got.kept_z);
         end
      end
   endfunction
endclass

module testbench;
   import vglpf_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int SettleCycles = 12;

   typedef enum int {AIM_LOW, AIM_HIGH, AIM_ANY} aim_pick_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_mode;
   logic signed [CoordW-1:0]   req_px;
   logic signed [CoordW-1:0]   req_py;
   logic signed [CoordW-1:0]   req_pz;
   logic [CellIdxW-1:0]        req_drain_cell;
   logic                       rsp_valid;
   logic [CellIdxW-1:0]        rsp_cell_index;
   logic                       rsp_dropped;
   logic                       rsp_occupied;
   logic signed [CoordW-1:0]   rsp_kept_x;
   logic signed [CoordW-1:0]   rsp_kept_y;
   logic signed [CoordW-1:0]   rsp_kept_z;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CsrIdxW-1:0]         csr_index;
   logic [CsrDataW-1:0]        csr_data;

   voxel_cell_tracker vox;
   int cycles = 0;
   longint hot_x[8], hot_y[8], hot_z[8];

   voxel_grid_lowest_point_filter DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // item taken at this edge
   always @(posedge clock) begin
      if (reset === 1'b0 && start === 1'b1 && busy === 1'b0)
         vox.accept_item(req_mode, req_px, req_py, req_pz, req_drain_cell);
   end

   always @(posedge clock) begin : watch_rsp
      rsp_type got;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         got.cell_index = rsp_cell_index;
         got.dropped = rsp_dropped;
         got.occupied = rsp_occupied;
         got.kept_x = rsp_kept_x;
         got.kept_y = rsp_kept_y;
         got.kept_z = rsp_kept_z;
         vox.check_word(got);
      end
   end

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0)
         q = q - 1;
      return q;
   endfunction

   function automatic longint ceil_div(longint a, longint b);
      return -floor_div(-a, b);
   endfunction

   // coordinate whose scaled floor lands on cell number target
   function automatic logic [31:0] aim(longint target, longint inv, aim_pick_type pick);
      longint lo, hi, r;
      if (inv == 0)
         return $urandom;
      lo = ceil_div(target * 64'sd4294967296, inv);
      hi = ceil_div((target + 1) * 64'sd4294967296, inv) - 1;
      if (lo < -64'sd2147483648) lo = -64'sd2147483648;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      if (lo > hi)
         return $urandom;
      r = longint'({$urandom, $urandom} >> 1);
      case (pick)
         AIM_LOW:  return lo[31:0];
         AIM_HIGH: return hi[31:0];
         default: begin
            r = lo + r % (hi - lo + 1);
            return r[31:0];
         end
      endcase
   endfunction

   function automatic aim_pick_type y_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return AIM_LOW;
      if (r < 35) return AIM_HIGH;
      return AIM_ANY;
   endfunction

   function automatic logic [31:0] noise();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(op_kind_type mode, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, logic [11:0] slot);
      req_mode <= mode;
      req_px <= px;
      req_py <= py;
      req_pz <= pz;
      req_drain_cell <= slot;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic insert_at(longint ix, longint iy, longint iz, aim_pick_type ypick);
      send_item(OP_INSERT, aim(ix + vox.org_x, vox.inv_x, AIM_ANY),
                aim(iy + vox.org_y, vox.inv_y, ypick),
                aim(iz + vox.org_z, vox.inv_z, AIM_ANY), 12'($urandom));
   endtask

   task automatic pause(int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed word has come and the block is idle
   task automatic wait_idle();
      start <= 1'b0;
      while (vox.owed_words.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      vox.set_reg(idx, value);
   endtask

   task automatic setup(int ivx, int ivy, int ivz, int ogx, int ogy, int ogz,
                        int spx, int spy);
      write_reg(CSR_INV_X, CsrDataW'(ivx));
      write_reg(CSR_INV_Y, CsrDataW'(ivy));
      write_reg(CSR_INV_Z, CsrDataW'(ivz));
      write_reg(CSR_ORG_X, CsrDataW'(ogx));
      write_reg(CSR_ORG_Y, CsrDataW'(ogy));
      write_reg(CSR_ORG_Z, CsrDataW'(ogz));
      write_reg(CSR_SPAN_X, CsrDataW'(spx));
      write_reg(CSR_SPAN_Y, CsrDataW'(spy));
      csr_valid <= 1'b0;
   endtask

   task automatic random_setup();
      int ivs[3];
      int ogs[3];
      int sx, sy;
      for (int k = 0; k < 3; k++) begin
         ivs[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16777215)
                                              : $urandom_range(16384, 1048576);
         ogs[k] = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 16777215)) - 8388608
                                              : int'($urandom_range(0, 400)) - 200;
      end
      sx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      sy = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      setup(ivs[0], ivs[1], ivs[2], ogs[0], ogs[1], ogs[2], sx, sy);
   endtask

   // mostly inserts, many aimed at a few busy cells so keep/replace/tie decisions pile up
   task automatic run_phase(int count);
      longint area;
      int sx, sy, sz, r, h, slot;
      sx = int'(vox.span_x);
      sy = int'(vox.span_y);
      area = vox.span_x * vox.span_y;
      sz = (area == 0 || area > GridCellsDefault) ? 1 : int'(GridCellsDefault / area);
      for (h = 0; h < 8; h++) begin
         hot_x[h] = $urandom_range(0, (sx > 0) ? sx - 1 : 0);
         hot_y[h] = $urandom_range(0, (sy > 0) ? sy - 1 : 0);
         hot_z[h] = $urandom_range(0, sz - 1);
      end
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25 && vox.kept_slots.size() != 0) begin
            if (vox.recent_slots.size() != 0 && $urandom_range(0, 2) != 0)
               slot = vox.recent_slots[$urandom_range(0, vox.recent_slots.size() - 1)];
            else
               slot = vox.kept_slots[$urandom_range(0, vox.kept_slots.size() - 1)];
            send_item(OP_DRAIN, $urandom, $urandom, $urandom, 12'(slot));
         end else if (r < 40) begin
            send_item(OP_INSERT, noise(), noise(), noise(), 12'($urandom));
         end else if (r < 85) begin
            h = $urandom_range(0, 7);
            insert_at(hot_x[h], hot_y[h], hot_z[h], y_pick());
         end else begin
            // one past each x and y edge, and one below z, now and then
            insert_at(longint'($urandom_range(0, sx + 1)) - 1,
                      longint'($urandom_range(0, sy + 1)) - 1,
                      longint'($urandom_range(0, sz)) - 1, y_pick());
         end
         if (i + 1 < count)
            pause((i >= count / 3 && i < count / 2) ? 0 : gap_len());
      end
      wait_idle();
   endtask

   initial begin
      vox = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= OP_INSERT;
      req_px <= '0;
      req_py <= '0;
      req_pz <= '0;
      req_drain_cell <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_INV_X;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // occupancy sweep follows reset
      @(posedge clock);
      do @(posedge clock); while (busy !== 1'b0);

      // default grid: 64 x 64 cells of 1 cm, one z layer of 2 m
      send_item(OP_INSERT, 32'd100, 32'd500, 32'd0, 12'd0);
      send_item(OP_INSERT, 32'd200, 32'd600, 32'd50, 12'd0);     // higher y, earlier kept
      send_item(OP_INSERT, 32'd300, 32'd500, 32'd60, 12'd0);     // equal y, earlier stays
      send_item(OP_INSERT, 32'd400, 32'd100, 32'd70, 12'd0);     // lower y replaces
      send_item(OP_DRAIN, 32'd0, 32'd0, 32'd0, 12'd0);
      send_item(OP_DRAIN, 32'd0, 32'd0, 32'd0, 12'd0);           // now empty
      send_item(OP_INSERT, 32'd0, 32'd0, 32'd0, 12'd0);
      insert_at(63, 63, 0, AIM_HIGH);                            // last cell
      send_item(OP_INSERT, 32'hFFFF_FFFF, 32'd0, 32'd0, 12'hFFF); // floors to -1
      insert_at(64, 0, 0, AIM_LOW);
      insert_at(0, 64, 0, AIM_LOW);
      insert_at(0, 0, 1, AIM_LOW);                               // index past the grid
      send_item(OP_INSERT, 32'd0, 32'd0, 32'hFFFF_FFFF, 12'd0);
      send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 12'hAAA);
      send_item(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 12'h555);
      send_item(OP_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_item(OP_DRAIN, 32'd0, 32'd0, 32'd0, 12'd0);
      run_phase(150);

      setup(65536, 65536, 65536, -8, -8, -2, 16, 16);
      run_phase(150);
      setup(16777215, 16777215, 1, -8388608, 8388607, 0, 4096, 1);
      run_phase(100);
      setup(0, 0, 0, 0, 0, 0, 1, 1);                             // everything in cell 0
      run_phase(40);
      setup(6553600, 6553600, 32768, 0, 0, 0, 0, 5);             // zero width: all drop
      run_phase(20);
      setup(65536, 16777215, 200000, 3, -100, 0, 1, 4096);
      run_phase(80);
      for (int k = 0; k < 3; k++) begin
         random_setup();
         run_phase(100);
      end

      repeat (SettleCycles) @(posedge clock);
      if (vox.bad_words == 0 && vox.owed_words.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ----- voxel_grid_lowest_point_filter.f -----
+incdir+rtl
rtl/vglpf_pkg.sv
rtl/vglpf_index.sv
rtl/vglpf_cell_store.sv
rtl/voxel_grid_lowest_point_filter.sv
tb/testbench.sv
